@@ rtl/tfn_pkg.sv @@
package tfn_pkg;

  // Default coordinate width (Q8.8).
  localparam int COORD_BITS_DEF = 16;
  // Output component width (Q1.14 plus sign).
  localparam int NORM_W = 16;
  // Magnitude width of a difference after range reduction.
  localparam int RDIFF_W = 16;
  // Width of one product and of one cross component.
  localparam int PROD_W = 34;
  // Magnitude width of a cross component before reduction.
  localparam int CRAW_W = 33;
  // Magnitude width of a cross component after reduction.
  localparam int CMAG_W = 30;
  // Width of one square and of the sum of squares.
  localparam int SQ_W = 60;
  localparam int SUM_W = 62;
  // Working width of the square root.
  localparam int ROOT_W = 64;
  // One square root step per result bit.
  localparam int RT_STEPS = 31;
  // Quotient bits; the quotient never exceeds 16384.
  localparam int QUO_W = 15;
  // Partial remainder width of the divider.
  localparam int REM_W = 47;
  // Width of the divisor 2L.
  localparam int LEN_W = 32;

  // Per-item side data that travels along the pipeline.
  typedef struct packed {
    logic [2:0][CMAG_W-1:0] mag;
    logic [2:0]             neg;
    logic                   zero;
  } side_t;

endpackage

@@ rtl/tfn_vtx_if.sv @@
interface tfn_vtx_if #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_x;
  logic signed [COORD_BITS-1:0] a_y;
  logic signed [COORD_BITS-1:0] a_z;
  logic signed [COORD_BITS-1:0] b_x;
  logic signed [COORD_BITS-1:0] b_y;
  logic signed [COORD_BITS-1:0] b_z;
  logic signed [COORD_BITS-1:0] c_x;
  logic signed [COORD_BITS-1:0] c_y;
  logic signed [COORD_BITS-1:0] c_z;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    output ready
  );
endinterface

@@ rtl/tfn_nrm_if.sv @@
interface tfn_nrm_if ();
  import tfn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [NORM_W-1:0] norm_x;
  logic signed [NORM_W-1:0] norm_y;
  logic signed [NORM_W-1:0] norm_z;
  logic                     degenerate;

  modport source (
    output valid, norm_x, norm_y, norm_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, norm_x, norm_y, norm_z, degenerate,
    output ready
  );
endinterface

@@ rtl/triangle_face_normal_top.sv @@
// Triangle face normal. Each request on vtx carries the vertices A, B and C of
// one triangle; the block answers on nrm with -(U x V)/|U x V| as three Q1.14
// components, where U = A - B and V = A - C, rounded half up. A triangle whose
// cross product is zero gives a zero normal with degenerate set. The block
// takes one request per clock unless a stall on nrm has filled every stage.
// The pipeline has 54 register stages, most of them in the 31-step square
// root and the three 15-step dividers, each step one pipeline stage. Every
// stage has its own valid bit and holds while it is full and the stage after
// it cannot advance, so a stall on nrm fills bubbles before it pushes back on vtx.
module triangle_face_normal_top #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tfn_vtx_if.sink   vtx,
  tfn_nrm_if.source nrm
);
  import tfn_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int MW = (DW > RDIFF_W) ? DW : RDIFF_W;

  // Stage numbering.
  localparam int ST_D   = 0;
  localparam int ST_R   = 1;
  localparam int ST_P   = 2;
  localparam int ST_C   = 3;
  localparam int ST_CR  = 4;
  localparam int ST_SQ  = 5;
  localparam int ST_SUM = 6;
  localparam int ST_RT0 = 7;
  localparam int ST_DV0 = ST_RT0 + RT_STEPS;
  localparam int ST_OUT = ST_DV0 + QUO_W;
  localparam int NST    = ST_OUT + 1;

  // Valid bits and per-stage advance.
  logic [NST-1:0] v;
  logic [NST-1:0] en;
  logic [NST-1:0] v_in;

  assign en[NST-1] = !v[NST-1] || nrm.ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !v[k] || en[k+1];
  end
  assign v_in = {v[NST-2:0], vtx.valid};
  assign vtx.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          v[k] <= v_in[k];
        end
      end
    end
  end

  // Stage 0: edge vectors U (0..2) and V (3..5).
  logic signed [DW-1:0] d [6];

  always_ff @(posedge clk) begin
    if (en[ST_D]) begin
      d[0] <= $signed({vtx.a_x[COORD_BITS-1], vtx.a_x})
            - $signed({vtx.b_x[COORD_BITS-1], vtx.b_x});
      d[1] <= $signed({vtx.a_y[COORD_BITS-1], vtx.a_y})
            - $signed({vtx.b_y[COORD_BITS-1], vtx.b_y});
      d[2] <= $signed({vtx.a_z[COORD_BITS-1], vtx.a_z})
            - $signed({vtx.b_z[COORD_BITS-1], vtx.b_z});
      d[3] <= $signed({vtx.a_x[COORD_BITS-1], vtx.a_x})
            - $signed({vtx.c_x[COORD_BITS-1], vtx.c_x});
      d[4] <= $signed({vtx.a_y[COORD_BITS-1], vtx.a_y})
            - $signed({vtx.c_y[COORD_BITS-1], vtx.c_y});
      d[5] <= $signed({vtx.a_z[COORD_BITS-1], vtx.a_z})
            - $signed({vtx.c_z[COORD_BITS-1], vtx.c_z});
    end
  end

  // Stage 1: shift all differences so that every magnitude fits 16 bits.
  logic [DW-1:0]           dmag [6];
  logic [DW-1:0]           dor;
  logic [5:0]              ds;
  logic [MW-1:0]           dsh  [6];
  logic signed [RDIFF_W:0] r1   [6];

  always_comb begin
    dor = '0;
    for (int i = 0; i < 6; i++) begin
      dmag[i] = d[i][DW-1] ? DW'(-d[i]) : DW'(d[i]);
      dor     = dor | dmag[i];
    end
    ds = '0;
    for (int b = RDIFF_W; b < DW; b++) begin
      if (dor[b]) begin
        ds = 6'(b - RDIFF_W + 1);
      end
    end
    for (int i = 0; i < 6; i++) begin
      dsh[i] = MW'(dmag[i]) >> ds;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_R]) begin
      for (int i = 0; i < 6; i++) begin
        r1[i] <= d[i][DW-1] ? -$signed({1'b0, dsh[i][RDIFF_W-1:0]})
                            :  $signed({1'b0, dsh[i][RDIFF_W-1:0]});
      end
    end
  end

  // Stage 2: the six products of the cross product.
  logic signed [PROD_W-1:0] p [6];

  always_ff @(posedge clk) begin
    if (en[ST_P]) begin
      p[0] <= PROD_W'(r1[1]) * PROD_W'(r1[5]);
      p[1] <= PROD_W'(r1[2]) * PROD_W'(r1[4]);
      p[2] <= PROD_W'(r1[2]) * PROD_W'(r1[3]);
      p[3] <= PROD_W'(r1[0]) * PROD_W'(r1[5]);
      p[4] <= PROD_W'(r1[0]) * PROD_W'(r1[4]);
      p[5] <= PROD_W'(r1[1]) * PROD_W'(r1[3]);
    end
  end

  // Stage 3: cross product components.
  logic signed [PROD_W-1:0] c [3];

  always_ff @(posedge clk) begin
    if (en[ST_C]) begin
      c[0] <= p[0] - p[1];
      c[1] <= p[2] - p[3];
      c[2] <= p[4] - p[5];
    end
  end

  // Stage 4: shift the cross components so that every magnitude fits 30 bits.
  logic [CRAW_W-1:0] cmag [3];
  logic [CRAW_W-1:0] cor;
  logic [1:0]        cts;
  side_t             sd [ST_CR:ST_OUT-1];

  always_comb begin
    cor = '0;
    for (int i = 0; i < 3; i++) begin
      cmag[i] = c[i][PROD_W-1] ? CRAW_W'(-c[i]) : CRAW_W'(c[i]);
      cor     = cor | cmag[i];
    end
    cts = '0;
    for (int b = CMAG_W; b < CRAW_W; b++) begin
      if (cor[b]) begin
        cts = 2'(b - CMAG_W + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_CR]) begin
      for (int i = 0; i < 3; i++) begin
        sd[ST_CR].mag[i] <= CMAG_W'(cmag[i] >> cts);
        sd[ST_CR].neg[i] <= c[i][PROD_W-1];
      end
      sd[ST_CR].zero <= 1'b0;
    end
  end

  // Stage 5: squares; a zero vector is flagged here.
  logic [SQ_W-1:0] sq [3];

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= SQ_W'(sd[ST_CR].mag[i]) * SQ_W'(sd[ST_CR].mag[i]);
      end
      sd[ST_SQ].mag  <= sd[ST_CR].mag;
      sd[ST_SQ].neg  <= sd[ST_CR].neg;
      sd[ST_SQ].zero <= (sd[ST_CR].mag[0] | sd[ST_CR].mag[1] | sd[ST_CR].mag[2]) == '0;
    end
  end

  // Stage 6: sum of squares.
  logic [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      sum         <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
      sd[ST_SUM]  <= sd[ST_SQ];
    end
  end

  // Square root, one result bit per stage.
  logic [ROOT_W-1:0] rt_n [RT_STEPS];
  logic [ROOT_W-1:0] rt_r [RT_STEPS];

  for (genvar j = 0; j < RT_STEPS; j++) begin : g_rt
    localparam int S = ST_RT0 + j;
    localparam logic [ROOT_W-1:0] BITV = ROOT_W'(1) << (2 * (RT_STEPS - 1 - j));
    logic [ROOT_W-1:0] n_prev;
    logic [ROOT_W-1:0] r_prev;
    logic [ROOT_W-1:0] trial;
    logic [ROOT_W-1:0] n_next;
    logic [ROOT_W-1:0] r_next;

    if (j == 0) begin : g_first
      assign n_prev = ROOT_W'(sum);
      assign r_prev = '0;
    end else begin : g_rest
      assign n_prev = rt_n[j-1];
      assign r_prev = rt_r[j-1];
    end

    always_comb begin
      trial = r_prev + BITV;
      if (n_prev >= trial) begin
        n_next = n_prev - trial;
        r_next = (r_prev >> 1) + BITV;
      end else begin
        n_next = n_prev;
        r_next = r_prev >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[S]) begin
        rt_n[j] <= n_next;
        rt_r[j] <= r_next;
        sd[S]   <= sd[S-1];
      end
    end
  end

  // Rounded division of each magnitude by the length, one quotient bit per stage.
  logic [REM_W-1:0] dv_rem [QUO_W][3];
  logic [QUO_W-1:0] dv_q   [QUO_W][3];
  logic [LEN_W-1:0] dv_d   [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_dv
    localparam int S = ST_DV0 + j;
    localparam int K = QUO_W - 1 - j;
    logic [REM_W-1:0] rem_prev [3];
    logic [QUO_W-1:0] q_prev   [3];
    logic [LEN_W-1:0] d_prev;
    logic [REM_W-1:0] cmpv;
    logic [REM_W-1:0] rem_next [3];
    logic [QUO_W-1:0] q_next   [3];

    if (j == 0) begin : g_first
      // Numerator 2*m*16384 + L over divisor 2L.
      assign d_prev = {rt_r[RT_STEPS-1][LEN_W-2:0], 1'b0};
      for (genvar i = 0; i < 3; i++) begin : g_n
        assign rem_prev[i] = (REM_W'(sd[S-1].mag[i]) << QUO_W)
                           + REM_W'(rt_r[RT_STEPS-1][LEN_W-2:0]);
        assign q_prev[i]   = '0;
      end
    end else begin : g_rest
      assign d_prev = dv_d[j-1];
      for (genvar i = 0; i < 3; i++) begin : g_n
        assign rem_prev[i] = dv_rem[j-1][i];
        assign q_prev[i]   = dv_q[j-1][i];
      end
    end

    always_comb begin
      cmpv = REM_W'(d_prev) << K;
      for (int i = 0; i < 3; i++) begin
        if (rem_prev[i] >= cmpv) begin
          rem_next[i] = rem_prev[i] - cmpv;
          q_next[i]   = {q_prev[i][QUO_W-2:0], 1'b1};
        end else begin
          rem_next[i] = rem_prev[i];
          q_next[i]   = {q_prev[i][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[S]) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem[j][i] <= rem_next[i];
          dv_q[j][i]   <= q_next[i];
        end
        dv_d[j] <= d_prev;
        sd[S]   <= sd[S-1];
      end
    end
  end

  // Output register: apply the sign (opposite to the cross component).
  logic signed [NORM_W-1:0] o_n [3];
  logic                     o_deg;
  side_t                    sd_last;

  assign sd_last = sd[ST_OUT-1];

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      for (int i = 0; i < 3; i++) begin
        if (sd_last.zero) begin
          o_n[i] <= '0;
        end else if (sd_last.neg[i]) begin
          o_n[i] <= $signed({1'b0, dv_q[QUO_W-1][i]});
        end else begin
          o_n[i] <= -$signed({1'b0, dv_q[QUO_W-1][i]});
        end
      end
      o_deg <= sd_last.zero;
    end
  end

  assign nrm.valid      = v[ST_OUT];
  assign nrm.norm_x     = o_n[0];
  assign nrm.norm_y     = o_n[1];
  assign nrm.norm_z     = o_n[2];
  assign nrm.degenerate = o_deg;

endmodule

@@ test/triangle_face_normal_top_tb.sv @@
module triangle_face_normal_top_tb;
  import tfn_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = COORD_BITS_DEF;
  localparam int NUM_RANDOM = 1330;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic                     degenerate;
  } normal_t;

  // Scoreboard for face normals: predicts each normal on acceptance and
  // compares results in order.
  class normal_scoreboard;
    normal_t pending[$];
    int mismatches;

    // Computes -(U x V)/|U x V| in Q1.14 for the given vertices.
    function automatic normal_t face_normal(coord_t v[9]);
      longint d[6];
      longint cr[3];
      longint unsigned mag[3];
      longint unsigned peak;
      longint unsigned total;
      longint unsigned root;
      longint unsigned rbit;
      longint unsigned rem;
      longint unsigned q;
      logic signed [NORM_W-1:0] comp[3];
      normal_t res;
      int sh;
      for (int i = 0; i < 3; i++) begin
        d[i] = longint'(v[i]) - longint'(v[3+i]);
        d[3+i] = longint'(v[i]) - longint'(v[6+i]);
      end
      // Bring the differences below 2^16 in magnitude.
      peak = 0;
      for (int i = 0; i < 6; i++)
        if ((d[i] < 0 ? -d[i] : d[i]) > peak) peak = d[i] < 0 ? -d[i] : d[i];
      sh = 0;
      while ((peak >> sh) >= (64'd1 << 16)) sh++;
      for (int i = 0; i < 6; i++)
        d[i] = d[i] < 0 ? -((-d[i]) >>> sh) : (d[i] >>> sh);
      cr[0] = d[1] * d[5] - d[2] * d[4];
      cr[1] = d[2] * d[3] - d[0] * d[5];
      cr[2] = d[0] * d[4] - d[1] * d[3];
      // Bring the cross components below 2^30 in magnitude.
      peak = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
        if (mag[i] > peak) peak = mag[i];
      end
      sh = 0;
      while ((peak >> sh) >= (64'd1 << 30)) sh++;
      total = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = mag[i] >> sh;
        total += mag[i] * mag[i];
      end
      if (total == 0) begin
        res.nx = '0;
        res.ny = '0;
        res.nz = '0;
        res.degenerate = 1'b1;
        return res;
      end
      // Integer square root, bit by bit.
      root = 0;
      rem = total;
      rbit = 64'd1 << 62;
      while (rbit > rem) rbit >>= 2;
      while (rbit != 0) begin
        if (rem >= root + rbit) begin
          rem -= root + rbit;
          root = (root >> 1) + rbit;
        end else begin
          root >>= 1;
        end
        rbit >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
        q = (2 * mag[i] * 16384 + root) / (2 * root);
        comp[i] = cr[i] < 0 ? NORM_W'(q) : NORM_W'(-q);
      end
      res.nx = comp[0];
      res.ny = comp[1];
      res.nz = comp[2];
      res.degenerate = 1'b0;
      return res;
    endfunction

    function void note_request(coord_t v[9]);
      pending = {pending, face_normal(v)};
    endfunction

    function void check_normal(normal_t got);
      normal_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected normal %0d %0d %0d deg=%0b",
                   got.nx, got.ny, got.nz, got.degenerate);
        return;
      end
      want = pending.pop_front();
      if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
          got.degenerate !== want.degenerate) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"normal mismatch: expected %0d %0d %0d deg=%0b, ",
                    "got %0d %0d %0d deg=%0b"},
                   want.nx, want.ny, want.nz, want.degenerate,
                   got.nx, got.ny, got.nz, got.degenerate);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;
  int   idle_cycles = 0;

  tfn_vtx_if #(.COORD_BITS(CB)) vtx ();
  tfn_nrm_if nrm ();

  normal_scoreboard normals = new();

  triangle_face_normal_top #(.COORD_BITS(CB)) dut (
    .clk(clk),
    .rst(rst),
    .vtx(vtx),
    .nrm(nrm)
  );

  always #10 clk = ~clk;

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    coord_t v[9];
    normal_t got;
    if (!rst) begin
      if (vtx.valid && vtx.ready) begin
        v = '{vtx.a_x, vtx.a_y, vtx.a_z, vtx.b_x, vtx.b_y, vtx.b_z,
              vtx.c_x, vtx.c_y, vtx.c_z};
        normals.note_request(v);
      end
      if (nrm.valid && nrm.ready) begin
        got.nx = nrm.norm_x;
        got.ny = nrm.norm_y;
        got.nz = nrm.norm_z;
        got.degenerate = nrm.degenerate;
        normals.check_normal(got);
      end
      if ((vtx.valid && vtx.ready) || (nrm.valid && nrm.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver stalls at random except in the calm stretch.
  always @(negedge clk) begin
    if (rst) nrm.ready <= 1'b0;
    else nrm.ready <= calm || ($urandom_range(99) >= 24);
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Presents one triangle and holds it until accepted.
  task automatic send_triangle(coord_t v[9]);
    while (!calm && $urandom_range(99) < 24) begin
      vtx.valid <= 1'b0;
      @(negedge clk);
    end
    vtx.valid <= 1'b1;
    {vtx.a_x, vtx.a_y, vtx.a_z} <= {v[0], v[1], v[2]};
    {vtx.b_x, vtx.b_y, vtx.b_z} <= {v[3], v[4], v[5]};
    {vtx.c_x, vtx.c_y, vtx.c_z} <= {v[6], v[7], v[8]};
    @(posedge clk);
    while (!vtx.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    vtx.valid <= 1'b0;
    while (normals.pending.size() != 0) @(negedge clk);
  endtask

  function automatic coord_t pick_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(64)) - 32);
      2: return $urandom_range(1) ? coord_t'(16'sh7fff) : coord_t'(16'sh8000);
      default: return coord_t'($signed($urandom_range(2048)) - 1024);
    endcase
  endfunction

  initial begin
    coord_t v[9];
    coord_t mx, mn;
    int mode;
    vtx.valid = 1'b0;
    vtx.a_x = '0; vtx.a_y = '0; vtx.a_z = '0;
    vtx.b_x = '0; vtx.b_y = '0; vtx.b_z = '0;
    vtx.c_x = '0; vtx.c_y = '0; vtx.c_z = '0;
    mx = coord_t'(16'sh7fff);
    mn = coord_t'(16'sh8000);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed triangles: axis planes, extremes, collinear and coincident points.
    send_triangle('{0, 0, 0, 256, 0, 0, 0, 256, 0});
    send_triangle('{0, 0, 0, 0, 256, 0, 256, 0, 0});
    send_triangle('{0, 0, 0, 0, 0, 256, 256, 0, 0});
    send_triangle('{5, 5, 5, 5, 5, 5, 5, 5, 5});
    send_triangle('{0, 0, 0, 1, 2, 3, 2, 4, 6});
    send_triangle('{0, 0, 0, -1, -1, -1, 3, 3, 3});
    send_triangle('{mx, mx, mx, mn, mn, mn, mn, mx, mn});
    send_triangle('{mn, mn, mn, mx, mn, mn, mn, mx, mn});
    send_triangle('{mx, mn, mx, mn, mx, mn, mx, mx, mn});
    send_triangle('{mn, mx, mn, mx, mn, mx, mn, mn, mx});
    send_triangle('{mx, mx, mx, mx, mx, mx, mn, mn, mn});
    send_triangle('{0, 0, 0, 1, 0, 0, 0, 1, 0});
    send_triangle('{0, 0, 0, 1, 1, 0, 1, 0, 1});
    send_triangle('{mx, 0, 0, mn, 0, 0, 0, mx, mn});
    send_triangle('{-1, -1, -1, 0, 0, 0, -1, 0, 0});
    send_triangle('{0, 0, 0, 3, 4, 0, 0, 0, 1});

    // Hold off until every directed result is back.
    wait_for_drain();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      calm = (n >= 400 && n < 600);
      mode = $urandom_range(3);
      for (int k = 0; k < 9; k++) v[k] = pick_coord(mode);
      // Occasionally force a degenerate triangle.
      if ($urandom_range(19) == 0)
        for (int k = 0; k < 3; k++) v[6+k] = v[3+k];
      send_triangle(v);
    end
    calm = 1'b0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (normals.mismatches == 0 && normals.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
